// ===== rtl/core/lpos_pkg.sv =====
package lpos_pkg;

  localparam int unsigned TDATA_W = 40;

  // Configuration register indexes.
  localparam logic [1:0] CFG_ACTIVE_LAYER = 2'd0;
  localparam logic [1:0] CFG_DRAW_MODE    = 2'd1;
  localparam logic [1:0] CFG_CLEAR_VALUE  = 2'd2;

  // Layer codes held in active_layer.
  localparam logic [4:0] LAYER_NONE   = 5'h00;
  localparam logic [4:0] LAYER_BASE   = 5'h01;
  localparam logic [4:0] LAYER_SECOND = 5'h02;
  localparam logic [4:0] LAYER_THIRD  = 5'h03;
  localparam logic [4:0] LAYER_FOURTH = 5'h04;
  localparam logic [4:0] LAYER_MAP    = 5'h10;

  // Per-pixel level codes.
  localparam logic [2:0] LV_BASE   = 3'd1;
  localparam logic [2:0] LV_SECOND = 3'd2;
  localparam logic [2:0] LV_THIRD  = 3'd3;
  localparam logic [2:0] LV_FOURTH = 3'd4;

  typedef enum logic [0:0] {
    KIND_SKIP,
    KIND_UPDATE
  } item_kind_e;

  typedef struct packed {
    logic [4:0]  active_layer;
    logic        draw_mode;
    logic [15:0] clear_value;
  } cfg_t;

  typedef struct packed {
    item_kind_e  kind;
    logic [8:0]  x;
    logic [7:0]  y;
    logic [15:0] value;
  } item_t;

  typedef struct packed {
    logic        write;
    logic [8:0]  x;
    logic [7:0]  y;
    logic [15:0] value;
  } result_t;

endpackage

// ===== rtl/core/lpos_front.sv =====
module lpos_front #(
  parameter int WIDTH  = 320,
  parameter int HEIGHT = 240,
  parameter int AW     = 17
) (
  input  logic [lpos_pkg::TDATA_W-1:0] s_tdata_i,   // pixel_x, pixel_y, pixel_value
  input  logic                         s_tvalid_i,
  output logic                         s_tready_o,
  input  lpos_pkg::cfg_t               cfg_i,
  input  logic                         q_full_i,
  input  logic                         clear_done_i,
  output logic                         q_push_o,
  output lpos_pkg::item_t              q_item_o,
  output logic [AW-1:0]                q_addr_o
);
  import lpos_pkg::*;

  logic [8:0]  x;
  logic [7:0]  y;
  logic        in_range;
  logic [17:0] lin_addr;

  assign x = s_tdata_i[8:0];
  assign y = s_tdata_i[16:9];

  assign in_range = ({1'b0, x} < 10'(WIDTH)) && ({1'b0, y} < 9'(HEIGHT));
  assign lin_addr = 18'(y) * 18'(WIDTH) + 18'(x);

  assign s_tready_o = clear_done_i && !q_full_i;
  assign q_push_o   = s_tvalid_i && s_tready_o;

  // Items that can touch no pixel state are marked KIND_SKIP and skip the memory write-back.
  always_comb begin
    q_item_o.x     = x;
    q_item_o.y     = y;
    q_item_o.value = s_tdata_i[32:17];
    if (in_range && (cfg_i.active_layer != LAYER_NONE)) begin
      q_item_o.kind = KIND_UPDATE;
      q_addr_o      = lin_addr[AW-1:0];
    end else begin
      q_item_o.kind = KIND_SKIP;
      q_addr_o      = '0;
    end
  end

endmodule

// ===== rtl/core/lpos_queue.sv =====
module lpos_queue #(
  parameter int W = 8
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_i,
  input  logic [W-1:0] push_data_i,
  input  logic         pop_i,
  output logic [W-1:0] pop_data_o,
  output logic         full_o,
  output logic         empty_o
);

  logic [W-1:0] slot_q [2];
  logic         wr_ptr_q, rd_ptr_q;
  logic [1:0]   cnt_q;

  assign full_o     = (cnt_q == 2'd2);
  assign empty_o    = (cnt_q == 2'd0);
  assign pop_data_o = slot_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 2'd1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// ===== rtl/core/lpos_back.sv =====
module lpos_back #(
  parameter int WIDTH      = 320,
  parameter int HEIGHT     = 240,
  parameter int PIXEL_BITS = 16,
  parameter int TOP_LEVEL  = 4,
  parameter int AW         = 17
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  lpos_pkg::cfg_t       cfg_i,
  input  logic                 q_empty_i,
  input  lpos_pkg::item_t      q_item_i,
  input  logic [AW-1:0]        q_addr_i,
  output logic                 q_pop_o,
  output logic                 clear_done_o,
  output lpos_pkg::result_t    res_o,
  output logic                 res_valid_o,
  input  logic                 res_ready_i
);
  import lpos_pkg::*;

  localparam int         DEPTH  = WIDTH * HEIGHT;
  localparam int         PW     = (PIXEL_BITS >= 16) ? 16 : PIXEL_BITS;
  localparam logic [2:0] TOP_LV = 3'(TOP_LEVEL);

  typedef struct packed {
    logic [2:0]    level;
    logic          second_valid;
    logic          third_valid;
    logic          map_valid;
    logic [PW-1:0] base;
    logic [PW-1:0] second;
    logic [PW-1:0] third;
    logic [PW-1:0] map;
  } pix_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC
  } state_e;

  state_e        state_q;
  logic [AW-1:0] clr_addr_q;
  item_t         cur_q;
  logic [AW-1:0] cur_addr_q;
  result_t       res_q;
  logic          res_valid_q;

  pix_t          mem_q [DEPTH];
  pix_t          rd_q;
  logic          mem_we;
  logic [AW-1:0] mem_wa;
  pix_t          mem_wd;

  pix_t          new_pix;
  logic          fb_wr;
  logic [PW-1:0] fv;
  logic [PW-1:0] d;
  logic [PW-1:0] clr;
  logic [2:0]    lv;
  logic          out_free;
  result_t       res_d;

  assign out_free     = !res_valid_q || res_ready_i;
  assign q_pop_o      = (state_q == ST_IDLE) && !q_empty_i;
  assign clear_done_o = (state_q != ST_CLEAR);
  assign res_o        = res_q;
  assign res_valid_o  = res_valid_q;

  // Read-modify-write of one pixel word: read in the pop cycle, write back in execute.
  always_comb begin
    d       = cur_q.value[PW-1:0];
    clr     = cfg_i.clear_value[PW-1:0];
    lv      = rd_q.level;
    new_pix = rd_q;
    fb_wr   = 1'b0;
    fv      = '0;
    unique case (cfg_i.active_layer)
      LAYER_NONE: begin
      end
      LAYER_BASE: begin
        if (cfg_i.draw_mode) begin
          if (lv < LV_SECOND) begin
            new_pix.base  = d;
            new_pix.level = LV_BASE;
            fv            = rd_q.map_valid ? (d ^ rd_q.map) : d;
            fb_wr         = 1'b1;
          end else if (lv <= TOP_LV) begin
            new_pix.base = d;
          end
        end else begin
          if (lv < LV_SECOND) begin
            new_pix.base = clr;
            fv           = rd_q.map_valid ? rd_q.map : clr;
            fb_wr        = 1'b1;
          end else if (lv <= TOP_LV) begin
            new_pix.base = clr;
          end
        end
      end
      LAYER_SECOND: begin
        if (cfg_i.draw_mode) begin
          if (lv < LV_THIRD) begin
            new_pix.second       = d;
            new_pix.second_valid = 1'b1;
            new_pix.level        = LV_SECOND;
            fv                   = d;
            fb_wr                = 1'b1;
          end else if (lv <= TOP_LV) begin
            new_pix.second       = d;
            new_pix.second_valid = 1'b1;
          end
        end else begin
          new_pix.second_valid = 1'b0;
          if (lv < LV_THIRD) begin
            fv            = rd_q.base;
            fb_wr         = 1'b1;
            new_pix.level = LV_BASE;
          end
        end
      end
      LAYER_THIRD: begin
        if (cfg_i.draw_mode) begin
          if (lv < LV_FOURTH) begin
            new_pix.third       = d;
            new_pix.third_valid = 1'b1;
            new_pix.level       = LV_THIRD;
            fv                  = d;
            fb_wr               = 1'b1;
          end else if (lv <= TOP_LV) begin
            new_pix.third       = d;
            new_pix.third_valid = 1'b1;
          end
        end else begin
          new_pix.third_valid = 1'b0;
          if (lv < LV_FOURTH) begin
            fb_wr = 1'b1;
            if (rd_q.second_valid) begin
              fv            = rd_q.second;
              new_pix.level = LV_SECOND;
            end else begin
              fv            = rd_q.base;
              new_pix.level = LV_BASE;
            end
          end
        end
      end
      LAYER_FOURTH: begin
        if (cfg_i.draw_mode) begin
          if (lv <= LV_FOURTH) begin
            new_pix.level = LV_FOURTH;
            fv            = d;
            fb_wr         = 1'b1;
          end
        end else begin
          if (lv > TOP_LV) begin
            fv    = clr;
            fb_wr = 1'b1;
          end
          if (lv <= LV_FOURTH) begin
            fb_wr = 1'b1;
            if (rd_q.third_valid) begin
              fv            = rd_q.third;
              new_pix.level = LV_THIRD;
            end else if (rd_q.second_valid) begin
              fv            = rd_q.second;
              new_pix.level = LV_SECOND;
            end else begin
              fv            = rd_q.base;
              new_pix.level = LV_BASE;
            end
          end
        end
      end
      LAYER_MAP: begin
        if (cfg_i.draw_mode) begin
          if (lv < LV_SECOND) begin
            new_pix.map       = d;
            new_pix.map_valid = 1'b1;
            new_pix.level     = LV_BASE;
            fv                = d ^ rd_q.base;
            fb_wr             = 1'b1;
          end else if (lv <= TOP_LV) begin
            new_pix.map       = d;
            new_pix.map_valid = 1'b1;
          end
        end else begin
          if (lv < LV_SECOND) begin
            new_pix.map_valid = 1'b0;
            fv                = rd_q.base;
            fb_wr             = 1'b1;
          end else if (lv <= TOP_LV) begin
            new_pix.map_valid = 1'b0;
          end
        end
      end
      default: begin
        if (lv > TOP_LV) begin
          fv    = cfg_i.draw_mode ? d : clr;
          fb_wr = 1'b1;
        end
      end
    endcase

    if ((cur_q.kind == KIND_UPDATE) && fb_wr) begin
      res_d.write = 1'b1;
      res_d.x     = cur_q.x;
      res_d.y     = cur_q.y;
      res_d.value = 16'(fv);
    end else begin
      res_d = '0;
    end
  end

  always_comb begin
    mem_we = 1'b0;
    mem_wa = cur_addr_q;
    mem_wd = new_pix;
    if (state_q == ST_CLEAR) begin
      mem_we = 1'b1;
      mem_wa = clr_addr_q;
      mem_wd = '0;
    end else if ((state_q == ST_EXEC) && out_free && (cur_q.kind == KIND_UPDATE)) begin
      mem_we = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_wa] <= mem_wd;
    end
    if (q_pop_o) begin
      rd_q <= mem_q[q_addr_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_addr_q  <= '0;
      res_valid_q <= 1'b0;
      cur_q       <= '0;
      cur_addr_q  <= '0;
      res_q       <= '0;
    end else begin
      // In execute the valid flag is either reloaded or still stalled.
      if (res_valid_q && res_ready_i && (state_q != ST_EXEC)) begin
        res_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_CLEAR: begin
          clr_addr_q <= clr_addr_q + 1'b1;
          if (clr_addr_q == AW'(DEPTH - 1)) begin
            state_q <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (q_pop_o) begin
            cur_q      <= q_item_i;
            cur_addr_q <= q_addr_i;
            state_q    <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          if (out_free) begin
            res_q       <= res_d;
            res_valid_q <= 1'b1;
            state_q     <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== rtl/core/layered_pixel_overlay_store.sv =====
// Each item passes through a read step, where it is popped and its pixel word read,
// and an execute step, where the word is written back and the result registered; a new
// item is popped only after the last has left execute, which a stalled result delays.
// Reset: configuration returns to its reset values; a clearing pass then zeroes the
// pixel memory, one pixel a cycle, with s_axis_tready held low until it finishes.
module layered_pixel_overlay_store #(
  parameter int WIDTH      = 320,
  parameter int HEIGHT     = 240,
  parameter int PIXEL_BITS = 16,
  parameter int TOP_LEVEL  = 4
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  input  logic [lpos_pkg::TDATA_W-1:0] s_axis_tdata,   // pixel_x, pixel_y, pixel_value
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  output logic [lpos_pkg::TDATA_W-1:0] m_axis_tdata,   // fb_x, fb_y, fb_value
  output logic                         m_axis_tuser,   // fb_write
  input  logic                         cfg_we_i,
  input  logic [1:0]                   cfg_idx_i,
  input  logic [15:0]                  cfg_data_i
);
  import lpos_pkg::*;

  localparam int DEPTH = WIDTH * HEIGHT;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int QW    = AW + $bits(item_t);

  cfg_t            cfg_q;
  logic            q_push, q_pop, q_full, q_empty, clear_done;
  item_t           push_item, pop_item;
  logic [AW-1:0]   push_addr, pop_addr;
  logic [QW-1:0]   pop_data;
  result_t         res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.active_layer <= LAYER_NONE;
      cfg_q.draw_mode    <= 1'b1;
      cfg_q.clear_value  <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_ACTIVE_LAYER: cfg_q.active_layer <= cfg_data_i[4:0];
        CFG_DRAW_MODE:    cfg_q.draw_mode    <= cfg_data_i[0];
        CFG_CLEAR_VALUE:  cfg_q.clear_value  <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  lpos_front #(
    .WIDTH  (WIDTH),
    .HEIGHT (HEIGHT),
    .AW     (AW)
  ) u_front (
    .s_tdata_i    (s_axis_tdata),
    .s_tvalid_i   (s_axis_tvalid),
    .s_tready_o   (s_axis_tready),
    .cfg_i        (cfg_q),
    .q_full_i     (q_full),
    .clear_done_i (clear_done),
    .q_push_o     (q_push),
    .q_item_o     (push_item),
    .q_addr_o     (push_addr)
  );

  lpos_queue #(
    .W (QW)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_data_i ({push_addr, push_item}),
    .pop_i       (q_pop),
    .pop_data_o  (pop_data),
    .full_o      (q_full),
    .empty_o     (q_empty)
  );

  assign pop_item = pop_data[$bits(item_t)-1:0];
  assign pop_addr = pop_data[QW-1:$bits(item_t)];

  lpos_back #(
    .WIDTH      (WIDTH),
    .HEIGHT     (HEIGHT),
    .PIXEL_BITS (PIXEL_BITS),
    .TOP_LEVEL  (TOP_LEVEL),
    .AW         (AW)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .q_empty_i    (q_empty),
    .q_item_i     (pop_item),
    .q_addr_i     (pop_addr),
    .q_pop_o      (q_pop),
    .clear_done_o (clear_done),
    .res_o        (res),
    .res_valid_o  (m_axis_tvalid),
    .res_ready_i  (m_axis_tready)
  );

  assign m_axis_tdata = {7'b0, res.value, res.y, res.x};
  assign m_axis_tuser = res.write;

endmodule

// ===== rtl/core/lpos_checker.sv =====
module lpos_checker #(
  parameter int WIDTH  = 320,
  parameter int HEIGHT = 240
) (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         s_axis_tready,
  input logic                         m_axis_tvalid,
  input logic                         m_axis_tready,
  input logic [lpos_pkg::TDATA_W-1:0] m_axis_tdata,
  input logic                         m_axis_tuser
);

  // A stalled result stays offered.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result dropped while stalled");

  // Right after reset the memory clear is running, so no item may be taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(!rst_ni) |-> !s_axis_tready)
    else $error("input ready during memory clear");

  // A result without a framebuffer write carries an all-zero payload.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser |-> (m_axis_tdata == '0))
    else $error("non-write result has nonzero payload");

  // A framebuffer write always lands inside the screen.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |->
      ({1'b0, m_axis_tdata[8:0]} < 10'(WIDTH)) && ({1'b0, m_axis_tdata[16:9]} < 9'(HEIGHT)))
    else $error("framebuffer write outside the screen");

endmodule

bind layered_pixel_overlay_store lpos_checker #(
  .WIDTH  (WIDTH),
  .HEIGHT (HEIGHT)
) u_lpos_checker (.*);

// ===== sim/testbench.sv =====
module testbench;
  import lpos_pkg::*;

  localparam int WIDTH      = 320;
  localparam int HEIGHT     = 240;
  localparam int PIXEL_BITS = 16;
  localparam int TOP_LEVEL  = 4;
  localparam int NUM_PIXELS = WIDTH * HEIGHT;
  localparam logic [15:0] PIX_MASK =
    (PIXEL_BITS >= 16) ? 16'hFFFF : 16'((1 << PIXEL_BITS) - 1);
  localparam int RANDOM_ITEMS = 1600;

  typedef struct packed {
    logic [8:0]  x;
    logic [7:0]  y;
    logic [15:0] value;
  } pixel_wr_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [TDATA_W-1:0]    s_axis_tdata = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [TDATA_W-1:0]    m_axis_tdata;
  logic                  m_axis_tuser;
  logic                  cfg_we_i = 1'b0;
  logic [1:0]            cfg_idx_i = CFG_ACTIVE_LAYER;
  logic [15:0]           cfg_data_i = '0;

  // Shadow of the configuration and of the per-pixel store.
  logic [4:0]  layer_sel = LAYER_NONE;
  logic        draw_sel = 1'b1;
  logic [15:0] clear_sel = '0;
  logic [2:0]  level_mem  [NUM_PIXELS];
  logic [15:0] base_mem   [NUM_PIXELS];
  logic [15:0] second_mem [NUM_PIXELS];
  logic [15:0] third_mem  [NUM_PIXELS];
  logic [15:0] map_mem    [NUM_PIXELS];
  logic        second_ok  [NUM_PIXELS];
  logic        third_ok   [NUM_PIXELS];
  logic        map_ok     [NUM_PIXELS];

  pixel_wr_t pending_writes[$];
  result_t   fb_expected[$];
  int        in_flight = 0;
  int        mismatches = 0;
  int        send_gap = 0;
  int        recv_stall = 0;
  bit        send_idle = 1'b1;
  bit        recv_idle = 1'b1;

  layered_pixel_overlay_store #(
    .WIDTH      (WIDTH),
    .HEIGHT     (HEIGHT),
    .PIXEL_BITS (PIXEL_BITS),
    .TOP_LEVEL  (TOP_LEVEL)
  ) uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    #5000000;
    $display("FAILURE");
    $finish;
  end

  // Applies one pixel write to the shadow store and returns the framebuffer update.
  function automatic result_t apply_pixel_write(logic [8:0] x, logic [7:0] y,
                                                logic [15:0] value);
    result_t     res;
    int          p;
    logic [2:0]  lv;
    logic [15:0] d;
    logic [15:0] clr;
    logic [15:0] fv;
    logic        wr;
    res = '0;
    fv  = '0;
    wr  = 1'b0;
    d   = value & PIX_MASK;
    clr = clear_sel & PIX_MASK;
    if (x >= WIDTH || y >= HEIGHT) return res;
    p  = int'(y) * WIDTH + int'(x);
    lv = level_mem[p];
    case (layer_sel)
      LAYER_NONE: ;
      LAYER_BASE: begin
        if (lv < LV_SECOND) begin
          base_mem[p] = draw_sel ? d : clr;
          if (draw_sel) begin
            level_mem[p] = LV_BASE;
            fv = map_ok[p] ? (d ^ map_mem[p]) : d;
          end else begin
            fv = map_ok[p] ? map_mem[p] : clr;
          end
          wr = 1'b1;
        end else if (lv <= TOP_LEVEL) begin
          base_mem[p] = draw_sel ? d : clr;
        end
      end
      LAYER_SECOND: begin
        if (draw_sel) begin
          if (lv <= TOP_LEVEL) begin
            second_mem[p] = d;
            second_ok[p]  = 1'b1;
          end
          if (lv <= LV_SECOND) begin
            level_mem[p] = LV_SECOND;
            fv = d;
            wr = 1'b1;
          end
        end else begin
          second_ok[p] = 1'b0;
          if (lv <= LV_SECOND) begin
            fv = base_mem[p];
            wr = 1'b1;
            level_mem[p] = LV_BASE;
          end
        end
      end
      LAYER_THIRD: begin
        if (draw_sel) begin
          if (lv <= TOP_LEVEL) begin
            third_mem[p] = d;
            third_ok[p]  = 1'b1;
          end
          if (lv <= LV_THIRD) begin
            level_mem[p] = LV_THIRD;
            fv = d;
            wr = 1'b1;
          end
        end else begin
          third_ok[p] = 1'b0;
          if (lv <= LV_THIRD) begin
            wr = 1'b1;
            if (second_ok[p]) begin
              fv = second_mem[p];
              level_mem[p] = LV_SECOND;
            end else begin
              fv = base_mem[p];
              level_mem[p] = LV_BASE;
            end
          end
        end
      end
      LAYER_FOURTH: begin
        if (draw_sel) begin
          if (lv <= LV_FOURTH) begin
            level_mem[p] = LV_FOURTH;
            fv = d;
            wr = 1'b1;
          end
        end else begin
          if (lv > TOP_LEVEL) begin
            fv = clr;
            wr = 1'b1;
          end
          if (lv <= LV_FOURTH) begin
            wr = 1'b1;
            if (third_ok[p]) begin
              fv = third_mem[p];
              level_mem[p] = LV_THIRD;
            end else if (second_ok[p]) begin
              fv = second_mem[p];
              level_mem[p] = LV_SECOND;
            end else begin
              fv = base_mem[p];
              level_mem[p] = LV_BASE;
            end
          end
        end
      end
      LAYER_MAP: begin
        if (lv <= TOP_LEVEL) begin
          map_ok[p] = draw_sel;
          if (draw_sel) map_mem[p] = d;
        end
        if (lv < LV_SECOND) begin
          wr = 1'b1;
          if (draw_sel) begin
            level_mem[p] = LV_BASE;
            fv = d ^ base_mem[p];
          end else begin
            fv = base_mem[p];
          end
        end
      end
      default: begin
        if (lv > TOP_LEVEL) begin
          fv = draw_sel ? d : clr;
          wr = 1'b1;
        end
      end
    endcase
    if (wr) begin
      res.write = 1'b1;
      res.x     = x;
      res.y     = y;
      res.value = fv;
    end
    return res;
  endfunction

  task automatic report_mismatch(input string msg);
    if (mismatches < 50) $display("MISMATCH at %0t: %s", $time, msg);
    mismatches++;
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] data);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
  endtask

  // Waits until the block is empty, then loads a new configuration.
  task automatic set_phase(input logic [4:0] layer, input logic mode,
                           input logic [15:0] clr);
    while (in_flight != 0) @(posedge clk_i);
    write_reg(CFG_ACTIVE_LAYER, {11'd0, layer});
    write_reg(CFG_DRAW_MODE, {15'd0, mode});
    write_reg(CFG_CLEAR_VALUE, clr);
    @(posedge clk_i);
    cfg_we_i  <= 1'b0;
    layer_sel = layer;
    draw_sel  = mode;
    clear_sel = clr;
  endtask

  task automatic push_pixel(input logic [8:0] x, input logic [7:0] y,
                            input logic [15:0] value);
    pixel_wr_t w;
    w.x     = x;
    w.y     = y;
    w.value = value;
    pending_writes.push_back(w);
    in_flight++;
  endtask

  always @(posedge clk_i) begin : sender
    pixel_wr_t nxt;
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready)
        fb_expected.push_back(apply_pixel_write(s_axis_tdata[8:0], s_axis_tdata[16:9],
                                                s_axis_tdata[32:17]));
      if (!s_axis_tvalid || s_axis_tready) begin
        if (send_gap != 0) begin
          send_gap      <= send_gap - 1;
          s_axis_tvalid <= 1'b0;
        end else if (pending_writes.size() != 0) begin
          nxt = pending_writes.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= {7'd0, nxt.value, nxt.y, nxt.x};
          send_gap      <= send_idle ? int'($urandom_range(0, 4)) : 0;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i) begin : receiver
    result_t got;
    result_t want;
    int      stall;
    if (rst_ni) begin
      stall = recv_stall;
      if (m_axis_tvalid && m_axis_tready) begin
        got.write = m_axis_tuser;
        got.x     = m_axis_tdata[8:0];
        got.y     = m_axis_tdata[16:9];
        got.value = m_axis_tdata[32:17];
        if (fb_expected.size() == 0) begin
          report_mismatch("framebuffer update with no pixel write pending");
        end else begin
          want = fb_expected.pop_front();
          in_flight--;
          if (got.write !== want.write)
            report_mismatch($sformatf("fb_write %b, expected %b", got.write, want.write));
          if (got.x !== want.x)
            report_mismatch($sformatf("fb_x %0d, expected %0d", got.x, want.x));
          if (got.y !== want.y)
            report_mismatch($sformatf("fb_y %0d, expected %0d", got.y, want.y));
          if (got.value !== want.value)
            report_mismatch($sformatf("fb_value %h, expected %h", got.value, want.value));
        end
        stall = recv_idle ? int'($urandom_range(0, 4)) : 0;
      end
      if (stall != 0) begin
        m_axis_tready <= 1'b0;
        recv_stall    <= stall - 1;
      end else begin
        m_axis_tready <= 1'b1;
        recv_stall    <= 0;
      end
    end
  end

  initial begin : stimulus
    int          counted;
    int          n;
    int          pick;
    logic [4:0]  layer;
    logic [15:0] clr;
    logic [8:0]  x;
    logic [7:0]  y;
    for (int i = 0; i < NUM_PIXELS; i++) begin
      level_mem[i]  = '0;
      base_mem[i]   = '0;
      second_mem[i] = '0;
      third_mem[i]  = '0;
      map_mem[i]    = '0;
      second_ok[i]  = 1'b0;
      third_ok[i]   = 1'b0;
      map_ok[i]     = 1'b0;
    end
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: field extremes, out-of-range coordinates, every layer drawn and
    // then peeled off again on one stacked pixel.
    set_phase(LAYER_BASE, 1'b1, 16'hFFFF);
    push_pixel(9'd0, 8'd0, 16'hFFFF);
    push_pixel(9'd319, 8'd239, 16'h0000);
    push_pixel(9'd320, 8'd0, 16'h1234);
    push_pixel(9'd0, 8'd240, 16'h5678);
    push_pixel(9'd511, 8'd255, 16'hFFFF);
    push_pixel(9'd5, 8'd5, 16'hA5A5);
    set_phase(LAYER_MAP, 1'b1, 16'h0000);
    push_pixel(9'd0, 8'd0, 16'h00FF);
    push_pixel(9'd5, 8'd5, 16'h1111);
    set_phase(LAYER_SECOND, 1'b1, 16'h0000);
    push_pixel(9'd0, 8'd0, 16'h2222);
    set_phase(LAYER_THIRD, 1'b1, 16'h0000);
    push_pixel(9'd0, 8'd0, 16'h3333);
    set_phase(LAYER_FOURTH, 1'b1, 16'h0000);
    push_pixel(9'd0, 8'd0, 16'h4444);
    // Lower layers written under a covering layer only update the saved values.
    set_phase(LAYER_BASE, 1'b1, 16'h0000);
    push_pixel(9'd0, 8'd0, 16'h0F0F);
    set_phase(LAYER_MAP, 1'b1, 16'h0000);
    push_pixel(9'd0, 8'd0, 16'hF000);
    set_phase(LAYER_FOURTH, 1'b0, 16'h0000);
    push_pixel(9'd0, 8'd0, 16'h0000);
    set_phase(LAYER_THIRD, 1'b0, 16'h0000);
    push_pixel(9'd0, 8'd0, 16'h0000);
    set_phase(LAYER_SECOND, 1'b0, 16'h0000);
    push_pixel(9'd0, 8'd0, 16'h0000);
    set_phase(LAYER_MAP, 1'b0, 16'h0000);
    push_pixel(9'd0, 8'd0, 16'h0000);
    set_phase(LAYER_BASE, 1'b0, 16'hFFFF);
    push_pixel(9'd0, 8'd0, 16'h0000);
    push_pixel(9'd5, 8'd5, 16'h0000);
    set_phase(LAYER_NONE, 1'b1, 16'h0000);
    push_pixel(9'd0, 8'd0, 16'hBEEF);
    set_phase(5'd31, 1'b1, 16'h0000);
    push_pixel(9'd0, 8'd0, 16'hCAFE);
    set_phase(5'd5, 1'b0, 16'hFFFF);
    push_pixel(9'd5, 8'd5, 16'h0000);

    // Random phases. Most writes land on a small patch so layers stack up and
    // come off again in all orders.
    counted = 0;
    while (counted < RANDOM_ITEMS) begin
      pick = $urandom_range(0, 19);
      if (pick == 0) begin
        layer = LAYER_NONE;
      end else if (pick == 1) begin
        n = $urandom_range(5, 30);
        if (n >= 16) n++;
        layer = 5'(n);
      end else begin
        case (pick % 5)
          0: layer = LAYER_BASE;
          1: layer = LAYER_SECOND;
          2: layer = LAYER_THIRD;
          3: layer = LAYER_FOURTH;
          default: layer = LAYER_MAP;
        endcase
      end
      case ($urandom_range(0, 5))
        0: clr = 16'h0000;
        1: clr = 16'hFFFF;
        default: clr = 16'($urandom);
      endcase
      send_idle = ($urandom_range(0, 3) != 0);
      recv_idle = ($urandom_range(0, 3) != 0);
      set_phase(layer, 1'($urandom_range(0, 1)), clr);
      n = $urandom_range(1, 30);
      repeat (n) begin
        pick = $urandom_range(0, 19);
        if (pick == 0) begin
          x = 9'($urandom);
          y = 8'($urandom);
        end else if (pick == 1) begin
          x = $urandom_range(0, 1) ? 9'(WIDTH - 1) : 9'd0;
          y = $urandom_range(0, 1) ? 8'(HEIGHT - 1) : 8'd0;
        end else begin
          x = 9'($urandom_range(0, 5));
          y = 8'($urandom_range(0, 3));
        end
        push_pixel(x, y, 16'($urandom));
        counted++;
      end
    end

    while (in_flight != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (mismatches == 0 && fb_expected.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/lpos_pkg.sv
rtl/core/lpos_front.sv
rtl/core/lpos_queue.sv
rtl/core/lpos_back.sv
rtl/core/layered_pixel_overlay_store.sv
rtl/core/lpos_checker.sv
sim/testbench.sv
